// File: src/rfp_pkg.sv
// rfp_pkg: constants and types shared by the rangefinder frame parser
// header bytes, frame byte positions, result and colour event codes
// no dependencies
package rfp_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [3:0]  pos_t;
    typedef logic [23:0] dist_t;
    typedef logic [1:0]  code_t;

    localparam byte_t HDR_FIRST  = 8'h57;
    localparam byte_t HDR_SECOND = 8'h00;

    localparam pos_t POS_HUNT     = 4'h0;
    localparam pos_t POS_HDR2     = 4'h1;
    localparam pos_t POS_DIST_LO  = 4'h8;
    localparam pos_t POS_DIST_MID = 4'h9;
    localparam pos_t POS_DIST_HI  = 4'hA;
    localparam pos_t POS_STATUS   = 4'hB;
    localparam pos_t POS_LAST     = 4'hF;

    localparam code_t RES_BAD     = 2'd0;
    localparam code_t RES_UPDATED = 2'd1;
    localparam code_t RES_STATUS  = 2'd2;

    localparam code_t EV_NONE    = 2'd0;
    localparam code_t EV_RECOVER = 2'd1;
    localparam code_t EV_WARN    = 2'd2;

endpackage

// File: src/rangefinder_frame_parser_core.sv
// rangefinder_frame_parser_core: byte-serial frame parser for a distance sensor link
// hunts the two-byte header, sums the frame, checks it and reports distance and colour events
// depends on rfp_pkg
//
// One received byte is taken per item, and a new byte can be accepted in every cycle
// while in_ready is high: the parse state advances in the cycle the byte is accepted,
// and the frame result for the sixteenth (checksum) byte sits in an output register
// from the next cycle on. Input ready stays high while the output register is empty
// or its result is being taken, so the only thing that stalls input is a result that
// waits downstream. Bytes that do not end a frame give no result. A wrong second
// header byte sends the parser back to hunting without testing that byte again
// as a first header byte. distance holds the last value from a good frame whose
// status byte was zero; colour_event reports warning on every good frame with a
// nonzero status and recovered on the first good zero-status frame after that.
module rangefinder_frame_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] distance,
    output logic [1:0]  frame_result,
    output logic [1:0]  colour_event
);

    rfp_pkg::pos_t  pos_reg,   pos_next;
    rfp_pkg::byte_t sum_reg,   sum_next;
    rfp_pkg::dist_t dbytes_reg, dbytes_next;
    rfp_pkg::byte_t status_reg, status_next;
    rfp_pkg::dist_t held_reg,  held_next;
    logic           warn_reg,  warn_next;

    logic           out_valid_reg, out_valid_next;
    rfp_pkg::dist_t dist_out_reg,  dist_out_next;
    rfp_pkg::code_t result_reg,    result_next;
    rfp_pkg::code_t event_reg,     event_next;

    logic accept;
    logic load_out;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        dbytes_next   = dbytes_reg;
        status_next   = status_reg;
        held_next     = held_reg;
        warn_next     = warn_reg;
        load_out      = 1'b0;
        result_next   = result_reg;
        event_next    = event_reg;
        if (accept)
        begin
            if (pos_reg == rfp_pkg::POS_HUNT)
            begin
                if (rx_byte == rfp_pkg::HDR_FIRST)
                begin
                    sum_next = rx_byte;
                    pos_next = rfp_pkg::POS_HDR2;
                end
            end
            else if (pos_reg == rfp_pkg::POS_HDR2)
            begin
                if (rx_byte == rfp_pkg::HDR_SECOND)
                begin
                    sum_next = sum_reg + rx_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    pos_next = rfp_pkg::POS_HUNT;
                end
            end
            else if (pos_reg != rfp_pkg::POS_LAST)
            begin
                sum_next = sum_reg + rx_byte;
                if (pos_reg == rfp_pkg::POS_DIST_LO)
                    dbytes_next[7:0] = rx_byte;
                else if (pos_reg == rfp_pkg::POS_DIST_MID)
                    dbytes_next[15:8] = rx_byte;
                else if (pos_reg == rfp_pkg::POS_DIST_HI)
                    dbytes_next[23:16] = rx_byte;
                else if (pos_reg == rfp_pkg::POS_STATUS)
                    status_next = rx_byte;
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                // checksum byte closes the frame
                pos_next = rfp_pkg::POS_HUNT;
                load_out = 1'b1;
                if (sum_reg != rx_byte)
                begin
                    result_next = rfp_pkg::RES_BAD;
                    event_next  = rfp_pkg::EV_NONE;
                end
                else if (status_reg == 8'h00)
                begin
                    held_next   = dbytes_reg;
                    result_next = rfp_pkg::RES_UPDATED;
                    warn_next   = 1'b0;
                    event_next  = warn_reg ? rfp_pkg::EV_RECOVER : rfp_pkg::EV_NONE;
                end
                else
                begin
                    warn_next   = 1'b1;
                    result_next = rfp_pkg::RES_STATUS;
                    event_next  = rfp_pkg::EV_WARN;
                end
            end
        end
        dist_out_next = load_out ? held_next : dist_out_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= rfp_pkg::POS_HUNT;
            sum_reg       <= '0;
            dbytes_reg    <= '0;
            status_reg    <= '0;
            held_reg      <= '0;
            warn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            dbytes_reg    <= dbytes_next;
            status_reg    <= status_next;
            held_reg      <= held_next;
            warn_reg      <= warn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, only meaningful while out_valid is high
    always_ff @(posedge clk)
    begin
        dist_out_reg <= dist_out_next;
        result_reg   <= result_next;
        event_reg    <= event_next;
    end

    assign out_valid    = out_valid_reg;
    assign distance     = dist_out_reg;
    assign frame_result = result_reg;
    assign colour_event = event_reg;

`ifndef ASSERT_OFF
    // a frame end always produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_reg == rfp_pkg::POS_LAST |=> out_valid_reg && pos_reg == rfp_pkg::POS_HUNT)
    else $error("frame end did not load a result");

    // a bad checksum never reports a colour event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg == rfp_pkg::RES_BAD |-> event_reg == rfp_pkg::EV_NONE)
    else $error("colour event on a bad frame");

    // a good frame with nonzero status always warns and leaves the warning flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg == rfp_pkg::RES_STATUS |-> event_reg == rfp_pkg::EV_WARN && warn_reg)
    else $error("status frame without warning");

    // waiting for the second header byte means the sum holds the first one
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == rfp_pkg::POS_HDR2 |-> sum_reg == rfp_pkg::HDR_FIRST)
    else $error("running sum wrong after first header byte");

    // a recovery event only follows a good zero-status frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && event_reg == rfp_pkg::EV_RECOVER |-> result_reg == rfp_pkg::RES_UPDATED && !warn_reg)
    else $error("recovery reported without a good frame");
`endif

endmodule
